// ----- sv/kd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and constants for the keystroke delay block.
package kd_pkg;

	localparam int RAND_W  = 31;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int PCT_W   = 7;
	localparam int HALF_W  = 16;
	localparam int PROD_W  = HALF_W + PCT_W;
	localparam int DIV_W   = HALF_W + 1;
	localparam int DELAY_W = 18;
	localparam int CNT_W   = 5;

	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;
	localparam int SCALED_W    = PROD_W + RECIP_W;

	localparam logic [PCT_W-1:0]   PCT_MAX = 7'd100;
	localparam logic [RECIP_W-1:0] RECIP   = 24'd10737419;

	typedef enum logic [IDX_W-1:0] {
		CFG_FAST_MODE  = 3'd0,
		CFG_BASE_DELAY = 3'd1,
		CFG_JITTER_PCT = 3'd2,
		CFG_BURST_INT  = 3'd3,
		CFG_PAUSE_MIN  = 3'd4,
		CFG_PAUSE_MAX  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		MOD_JITTER = 1'b0,
		MOD_PAUSE  = 1'b1
	} mod_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_HALF,
		S_JSTART,
		S_JWAIT,
		S_PSTART,
		S_PWAIT,
		S_FIN
	} kd_state_t;

	typedef struct packed {
		logic     load;
		logic     mul;
		logic     half;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     jclear;
		logic     jcap;
		logic     pclear;
		logic     pcap;
		logic     finish;
	} kd_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic fast_mode;
		logic half_zero;
		logic pause_skip;
		logic out_free;
	} kd_stat_t;

endpackage

// ----- sv/kd_in_if.sv -----
`timescale 1ns / 1ps
// Keystroke request channel carrying the two random words.
interface kd_in_if;
	logic                       valid;
	logic                       ready;
	logic [kd_pkg::RAND_W-1:0] rand_jitter;
	logic [kd_pkg::RAND_W-1:0] rand_pause;

	modport source (output valid, output rand_jitter, output rand_pause, input ready);
	modport sink (input valid, input rand_jitter, input rand_pause, output ready);
endinterface

// ----- sv/kd_out_if.sv -----
`timescale 1ns / 1ps
// Delay result channel.
interface kd_out_if;
	logic                        valid;
	logic                        ready;
	logic [kd_pkg::DELAY_W-1:0] delay_ms;
	logic                        pause_added;

	modport source (output valid, output delay_ms, output pause_added, input ready);
	modport sink (input valid, input delay_ms, input pause_added, output ready);
endinterface

// ----- sv/kd_mod.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module kd_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kd_pkg::RAND_W-1:0] dividend,
	input  logic [kd_pkg::DIV_W-1:0]  divisor,
	output logic                       done,
	output logic [kd_pkg::DIV_W-1:0]  rem
);
	import kd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAND_W-1:0] dvd_q;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W-1:0]  rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[RAND_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = DIV_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q)
		else $error("remainder not below divisor");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a running division");
`endif

endmodule

// ----- sv/kd_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for one keystroke: scale, jitter draw, pause draw, result; max-speed mode goes straight to the result.
module kd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kd_pkg::kd_stat_t stat,
	output kd_pkg::kd_cmd_t  cmd
);
	import kd_pkg::*;

	kd_state_t state_q;
	kd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.fast_mode ? S_FIN : S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_HALF;
			end
			S_HALF: begin
				cmd.half = 1'b1;
				state_d  = S_JSTART;
			end
			S_JSTART: begin
				if (stat.half_zero) begin
					cmd.jclear = 1'b1;
					state_d    = S_PSTART;
				end else begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = MOD_JITTER;
					state_d       = S_JWAIT;
				end
			end
			S_JWAIT: begin
				if (stat.mod_done) begin
					cmd.jcap = 1'b1;
					state_d  = S_PSTART;
				end
			end
			S_PSTART: begin
				if (stat.pause_skip) begin
					cmd.pclear = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = MOD_PAUSE;
					state_d       = S_PWAIT;
				end
			end
			S_PWAIT: begin
				if (stat.mod_done) begin
					cmd.pcap = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mod_done |-> (state_q == S_JWAIT || state_q == S_PWAIT))
		else $error("remainder finished outside a wait state");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != S_IDLE)
		else $error("accepted beat did not start work");
	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result written into a full output register");
`endif

endmodule

// ----- sv/kd_dpath.sv -----
`timescale 1ns / 1ps
// Registers, key counter, jitter scaling, remainder draws and result register.
module kd_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [kd_pkg::IDX_W-1:0]    cfg_index,
	input  logic [kd_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic [kd_pkg::RAND_W-1:0]   rand_jitter,
	input  logic [kd_pkg::RAND_W-1:0]   rand_pause,
	input  kd_pkg::kd_cmd_t              cmd,
	output kd_pkg::kd_stat_t             stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kd_pkg::DELAY_W-1:0]  out_delay_ms,
	output logic                         out_pause_added
);
	import kd_pkg::*;

	logic                max_q;
	logic [CFG_W-1:0]    base_q;
	logic [PCT_W-1:0]    pct_q;
	logic [CFG_W-1:0]    bi_q;
	logic [CFG_W-1:0]    pmin_q;
	logic [CFG_W-1:0]    pmax_q;
	logic [CFG_W-1:0]    kp_q;

	logic [RAND_W-1:0]   rj_q;
	logic [RAND_W-1:0]   rp_q;
	logic                due_q;
	logic [PROD_W-1:0]   prod_s1;
	logic [SCALED_W-1:0] scaled_s2;
	logic [HALF_W-1:0]   half_q;
	logic [DIV_W-1:0]    jrem_q;
	logic [DIV_W-1:0]    prem_q;

	logic                out_valid_q;
	logic [DELAY_W-1:0]  delay_q;
	logic                added_q;

	logic [CFG_W-1:0]    kp_inc;
	logic                due_d;
	logic [PCT_W-1:0]    pct_lim;
	logic [DIV_W-1:0]    span;
	logic [DIV_W-1:0]    range_w;
	logic                range_empty;
	logic [RAND_W-1:0]   mod_dvd;
	logic [DIV_W-1:0]    mod_div;
	logic                mod_done;
	logic [DIV_W-1:0]    mod_rem;
	logic [DELAY_W-1:0]  jit;
	logic [DELAY_W-1:0]  jit_clamped;
	logic [DELAY_W-1:0]  pause_ms;
	logic [DELAY_W-1:0]  delay_d;
	logic                out_free;

	assign kp_inc      = kp_q + 1'b1;
	assign due_d       = (bi_q != '0) && (kp_inc >= bi_q);
	assign pct_lim     = (pct_q > PCT_MAX) ? PCT_MAX : pct_q;
	assign span        = {half_q, 1'b1};
	assign range_empty = pmax_q <= pmin_q;
	assign range_w     = DIV_W'(pmax_q) - DIV_W'(pmin_q) + DIV_W'(1);
	assign mod_dvd     = (cmd.mod_sel == MOD_PAUSE) ? rp_q : rj_q;
	assign mod_div     = (cmd.mod_sel == MOD_PAUSE) ? range_w : span;

	assign jit         = DELAY_W'(base_q) + DELAY_W'(jrem_q) - DELAY_W'(half_q);
	assign jit_clamped = (jit == '0) ? DELAY_W'(1) : jit;
	assign pause_ms    = DELAY_W'(pmin_q) + DELAY_W'(prem_q);

	always_comb begin
		if (max_q) begin
			delay_d = DELAY_W'(1);
		end else if (due_q) begin
			delay_d = jit_clamped + pause_ms;
		end else begin
			delay_d = jit_clamped;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= 1'b0;
			base_q <= CFG_W'(1);
			pct_q  <= '0;
			bi_q   <= '0;
			pmin_q <= '0;
			pmax_q <= '0;
			kp_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FAST_MODE: begin
					max_q <= cfg_wdata[0];
					kp_q  <= '0;
				end
				CFG_BASE_DELAY: begin
					base_q <= cfg_wdata;
					kp_q   <= '0;
				end
				CFG_JITTER_PCT: begin
					pct_q <= cfg_wdata[PCT_W-1:0];
					kp_q  <= '0;
				end
				CFG_BURST_INT: begin
					bi_q <= cfg_wdata;
					kp_q <= '0;
				end
				CFG_PAUSE_MIN: begin
					pmin_q <= cfg_wdata;
					kp_q   <= '0;
				end
				CFG_PAUSE_MAX: begin
					pmax_q <= cfg_wdata;
					kp_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.load) begin
			kp_q <= due_d ? '0 : kp_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rj_q    <= rand_jitter;
			rp_q    <= rand_pause;
			due_q   <= due_d;
			prod_s1 <= PROD_W'(base_q) * PROD_W'(pct_lim);
		end
		if (cmd.mul) begin
			scaled_s2 <= SCALED_W'(prod_s1) * SCALED_W'(RECIP);
		end
		if (cmd.half) begin
			half_q <= scaled_s2[RECIP_SHIFT +: HALF_W];
		end
		if (cmd.jclear) begin
			jrem_q <= '0;
		end else if (cmd.jcap) begin
			jrem_q <= mod_rem;
		end
		if (cmd.pclear) begin
			prem_q <= '0;
		end else if (cmd.pcap) begin
			prem_q <= mod_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			delay_q <= delay_d;
			added_q <= due_q && !max_q;
		end
	end

	kd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_div),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign stat.mod_done   = mod_done;
	assign stat.fast_mode  = max_q;
	assign stat.half_zero  = half_q == '0;
	assign stat.pause_skip = !due_q || range_empty;
	assign stat.out_free   = out_free;

	assign out_valid       = out_valid_q;
	assign out_delay_ms    = delay_q;
	assign out_pause_added = added_q;

`ifndef SYNTHESIS
	a_delay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> delay_q != '0)
		else $error("zero delay in result register");
	a_pos_below_interval: assert property (@(posedge clk) disable iff (!arst_n)
		bi_q != '0 |-> kp_q < bi_q)
		else $error("key position at or above burst interval");
	a_half_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.jcap |-> half_q <= base_q)
		else $error("jitter half-width above base delay");
	a_max_no_pause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && added_q |-> !max_q)
		else $error("pause flagged in max-speed mode");
`endif

endmodule

// ----- sv/jittered_keystroke_delay_top.sv -----
`timescale 1ns / 1ps
// Keystroke delay top: one request beat in, one delay beat out.
// Max-speed mode goes straight to the result; otherwise the request is scaled, then takes
// a remainder draw on the shared bit-serial unit for jitter when the half-width is nonzero
// and for the pause when due with a nonempty range, and then the result is written.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset clears the registers to their defaults, the key position and the output valid.
module jittered_keystroke_delay_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [kd_pkg::IDX_W-1:0] cfg_index,
	input  logic [kd_pkg::CFG_W-1:0] cfg_wdata,
	kd_in_if.sink                     key_in,
	kd_out_if.source                  delay_out
);
	import kd_pkg::*;

	kd_cmd_t  cmd;
	kd_stat_t stat;
	logic     in_ready;

	kd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (key_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kd_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.rand_jitter     (key_in.rand_jitter),
		.rand_pause      (key_in.rand_pause),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (delay_out.valid),
		.out_ready       (delay_out.ready),
		.out_delay_ms    (delay_out.delay_ms),
		.out_pause_added (delay_out.pause_added)
	);

	assign key_in.ready = in_ready;

endmodule
